### rtl/isfd_pkg.sv
// Shared types and constants for the serial inertial sensor frame decoder.
package isfd_pkg;

  localparam int BYTE_W   = 8;
  localparam int RAW_W    = 16;
  localparam int SCALE_W  = 32;
  localparam int AXIS_W   = RAW_W + SCALE_W;
  localparam int POS_W    = 4;
  localparam int STORE_N  = 7;                      // type byte plus six axis bytes
  localparam int STORE_AW = $clog2(STORE_N);
  localparam int CFG_AW   = 1;
  localparam int OUT_TDATA_W = ((3 * AXIS_W + 2 + 7) / 8) * 8;

  localparam logic [BYTE_W-1:0] HDR_BYTE   = 8'h55;
  localparam logic [BYTE_W-1:0] TYPE_ACCEL = 8'h51;
  localparam logic [BYTE_W-1:0] TYPE_GYRO  = 8'h52;
  localparam logic [POS_W-1:0]  SUM_LEN    = 4'd10;

  localparam logic [SCALE_W-1:0] SCALE_ONE = 32'h0100_0000;

  // Input beat kind (carried on s_tuser)
  localparam logic CMD_DATA  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // Result kind (carried on m_tuser)
  localparam logic KIND_ACCEL = 1'b0;
  localparam logic KIND_GYRO  = 1'b1;

  // Register indexes
  localparam logic [CFG_AW-1:0] REG_ACC_GAIN  = 1'd0;
  localparam logic [CFG_AW-1:0] REG_RATE_GAIN = 1'd1;

  // Decoded frame handed from the parser to the scaler
  typedef struct packed {
    logic                    kind;
    logic signed [RAW_W-1:0] raw_x;
    logic signed [RAW_W-1:0] raw_y;
    logic signed [RAW_W-1:0] raw_z;
    logic                    accel_seen;
    logic                    gyro_seen;
  } isfd_rec_t;

endpackage

### rtl/isfd_framer.sv
// Byte framer: header hunt, running checksum, type check and seen flags.
module isfd_framer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_cmd,
  input  logic [isfd_pkg::BYTE_W-1:0]     in_byte,
  output logic                            rec_valid,
  input  logic                            rec_ready,
  output isfd_pkg::isfd_rec_t             rec
);

  logic [isfd_pkg::POS_W-1:0]  byte_position, byte_position_next;
  logic [isfd_pkg::BYTE_W-1:0] running_sum, running_sum_next;
  logic                        accel_flag, accel_flag_next;
  logic                        gyro_flag, gyro_flag_next;
  logic [isfd_pkg::BYTE_W-1:0] frame_bytes [isfd_pkg::STORE_N];
  logic                        store_en;
  logic [isfd_pkg::STORE_AW-1:0] store_idx;
  logic                        emit;
  logic                        emit_kind;
  logic                        in_acc;

  assign in_ready  = !rec_valid || rec_ready;
  assign in_acc    = in_valid && in_ready;
  assign store_idx = isfd_pkg::STORE_AW'(byte_position - 4'd1);

  always_comb begin
    byte_position_next = byte_position;
    running_sum_next   = running_sum;
    accel_flag_next    = accel_flag;
    gyro_flag_next     = gyro_flag;
    store_en           = 1'b0;
    emit               = 1'b0;
    emit_kind          = isfd_pkg::KIND_ACCEL;
    if (in_acc) begin
      if (in_cmd == isfd_pkg::CMD_CLEAR) begin
        accel_flag_next = 1'b0;
        gyro_flag_next  = 1'b0;
      end else if (byte_position == '0 || byte_position > isfd_pkg::SUM_LEN) begin
        if (in_byte == isfd_pkg::HDR_BYTE) begin
          byte_position_next = 4'd1;
          running_sum_next   = in_byte;
        end else begin
          byte_position_next = '0;
        end
      end else if (byte_position < isfd_pkg::SUM_LEN) begin
        store_en           = (byte_position <= 4'(isfd_pkg::STORE_N));
        running_sum_next   = running_sum + in_byte;
        byte_position_next = byte_position + 4'd1;
      end else begin
        byte_position_next = '0;
        if (in_byte == running_sum) begin
          if (frame_bytes[0] == isfd_pkg::TYPE_ACCEL) begin
            accel_flag_next = 1'b1;
            emit            = 1'b1;
            emit_kind       = isfd_pkg::KIND_ACCEL;
          end else if (frame_bytes[0] == isfd_pkg::TYPE_GYRO) begin
            gyro_flag_next = 1'b1;
            emit           = 1'b1;
            emit_kind      = isfd_pkg::KIND_GYRO;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      running_sum   <= '0;
      accel_flag    <= 1'b0;
      gyro_flag     <= 1'b0;
      rec_valid     <= 1'b0;
    end else begin
      byte_position <= byte_position_next;
      running_sum   <= running_sum_next;
      accel_flag    <= accel_flag_next;
      gyro_flag     <= gyro_flag_next;
      if (emit) begin
        rec_valid <= 1'b1;
      end else if (rec_ready) begin
        rec_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store_en) begin
      frame_bytes[store_idx] <= in_byte;
    end
    if (emit) begin
      rec.kind       <= emit_kind;
      rec.raw_x      <= {frame_bytes[2], frame_bytes[1]};
      rec.raw_y      <= {frame_bytes[4], frame_bytes[3]};
      rec.raw_z      <= {frame_bytes[6], frame_bytes[5]};
      rec.accel_seen <= accel_flag_next;
      rec.gyro_seen  <= gyro_flag_next;
    end
  end

endmodule

### rtl/isfd_scaler.sv
// Axis scaler: three 16x32 signed multiplies into the result register.
module isfd_scaler (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 rec_valid,
  output logic                                 rec_ready,
  input  isfd_pkg::isfd_rec_t                  rec,
  input  logic [isfd_pkg::SCALE_W-1:0]         acc_gain,
  input  logic [isfd_pkg::SCALE_W-1:0]         rate_gain,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_kind,
  output logic [isfd_pkg::OUT_TDATA_W-1:0]     out_data
);

  logic signed [isfd_pkg::AXIS_W-1:0] scale_ext;
  logic signed [isfd_pkg::AXIS_W-1:0] px, py, pz;
  logic [isfd_pkg::SCALE_W-1:0]       scale_sel;
  logic                               load;

  assign rec_ready = !out_valid || out_ready;
  assign load      = rec_valid && rec_ready;
  assign scale_sel = (rec.kind == isfd_pkg::KIND_GYRO) ? rate_gain : acc_gain;
  assign scale_ext = isfd_pkg::AXIS_W'($signed(scale_sel));

  assign px = isfd_pkg::AXIS_W'($signed(rec.raw_x)) * scale_ext;
  assign py = isfd_pkg::AXIS_W'($signed(rec.raw_y)) * scale_ext;
  assign pz = isfd_pkg::AXIS_W'($signed(rec.raw_z)) * scale_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind <= rec.kind;
      out_data <= {{(isfd_pkg::OUT_TDATA_W - 3 * isfd_pkg::AXIS_W - 2){1'b0}},
                   rec.gyro_seen, rec.accel_seen, pz, py, px};
    end
  end

endmodule

### rtl/imu_serial_frame_decoder.sv
// Top level of the serial inertial sensor frame decoder.
//
// Takes one serial byte per beat on the slave stream and hunts for the
// header 0x55, then collects an 11-byte frame: header, type, six bytes of
// little-endian signed 16-bit X/Y/Z, two spare bytes and a checksum equal
// to the 8-bit wrapping sum of the first ten bytes (kept as a running sum).
// A good frame of type 0x51 (acceleration) or 0x52 (angular rate) emits one
// master beat with each axis multiplied by the Q8.24 scale register for its
// type, giving exact 48-bit Q.24 products, plus the sticky seen flags as
// they stand after that frame. A beat with s_tuser high clears both seen
// flags, emits nothing and leaves the framing state alone. Bad checksums and
// other types emit nothing. Rate: one byte per clock, sustained; s_tready
// only drops while both the parser's frame register and the result register
// hold beats that the master side has not taken. The checksum byte's result
// is registered in the frame parser register, then passes through the three
// parallel 16x32 multipliers into the result register.
// Write the scale registers only while no frame is in flight.
module imu_serial_frame_decoder (
  input  logic                                clk,
  input  logic                                rst,
  // slave stream: serial bytes
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [7:0]                          s_tdata,   // [7:0] data_byte
  input  logic                                s_tuser,   // [0] cmd
  // master stream: scaled samples
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [47:0] axis_x, [95:48] axis_y, [143:96] axis_z, [144] accel_seen,
  // [145] gyro_seen, [151:146] zero
  output logic [isfd_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic                                m_tuser,   // [0] frame_kind
  // register write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [isfd_pkg::CFG_AW-1:0]         cfg_addr,
  input  logic [isfd_pkg::SCALE_W-1:0]        cfg_data
);

  logic [isfd_pkg::SCALE_W-1:0] acc_gain;
  logic [isfd_pkg::SCALE_W-1:0] rate_gain;
  logic                         rec_valid;
  logic                         rec_ready;
  isfd_pkg::isfd_rec_t          rec;

  // Register writes are always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_gain  <= isfd_pkg::SCALE_ONE;
      rate_gain <= isfd_pkg::SCALE_ONE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_addr)
        isfd_pkg::REG_ACC_GAIN:  acc_gain  <= cfg_data;
        isfd_pkg::REG_RATE_GAIN: rate_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  // Frame parser: advance the byte position, hold the running sum,
  // drop frames with a bad checksum or an unknown type
  isfd_framer u_framer (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_cmd    (s_tuser),
    .in_byte   (s_tdata),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .rec       (rec)
  );

  // Scale the three axes and hold the result beat until it is taken
  isfd_scaler u_scaler (
    .clk         (clk),
    .rst         (rst),
    .rec_valid   (rec_valid),
    .rec_ready   (rec_ready),
    .rec         (rec),
    .acc_gain    (acc_gain),
    .rate_gain   (rate_gain),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_kind    (m_tuser),
    .out_data    (m_tdata)
  );

endmodule

### rtl/isfd_checker.sv
// Port-level checks for the frame decoder, bound to the top level.
module isfd_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic                             s_tuser,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [isfd_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic                             m_tuser
);

  localparam int ACCEL_BIT = 3 * isfd_pkg::AXIS_W;
  localparam int GYRO_BIT  = 3 * isfd_pkg::AXIS_W + 1;

  // A stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // No result beat right out of reset
  a_reset: assert property (@(posedge clk)
    !rst && $past(rst) |-> !m_tvalid)
    else $error("result beat after reset");

  // The seen flag of the frame's own kind is always set in its beat
  a_seen: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tuser == isfd_pkg::KIND_ACCEL) ? m_tdata[ACCEL_BIT] : m_tdata[GYRO_BIT]))
    else $error("seen flag missing for frame kind");

  // A new result beat follows a taken data byte, via the parser and result registers
  a_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready && (s_tuser == isfd_pkg::CMD_DATA), 2))
    else $error("result beat without a checksum byte");

endmodule

bind imu_serial_frame_decoder isfd_checker u_isfd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

### test/tb_imu_serial_frame_decoder.sv
// Self-checking testbench for the serial inertial sensor frame decoder.
`timescale 1ns / 100ps

module tb_imu_serial_frame_decoder;

  localparam int IDLE_LIMIT = 1000;   // cycles with no beat on any channel

  typedef struct packed {
    logic       cmd;
    logic [7:0] data;
  } serial_beat_t;

  typedef struct packed {
    logic        kind;
    logic [47:0] ax;
    logic [47:0] ay;
    logic [47:0] az;
    logic        accel_seen;
    logic        gyro_seen;
  } frame_sample_t;

  // DUT ports; the driven inputs are known from time zero
  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [7:0]                       s_tdata = '0;    // [7:0] data_byte
  logic                             s_tuser = 1'b0;  // [0] cmd
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  // [47:0] axis_x, [95:48] axis_y, [143:96] axis_z, [144] accel_seen, [145] gyro_seen
  logic [isfd_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                             m_tuser;         // [0] frame_kind
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [isfd_pkg::CFG_AW-1:0]      cfg_addr = '0;
  logic [isfd_pkg::SCALE_W-1:0]     cfg_data = '0;

  imu_serial_frame_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Stimulus and scoreboard state
  serial_beat_t  serial_q[$];     // beats waiting to be driven
  frame_sample_t frames_due[$];   // decoded samples the DUT still owes us
  int            items_queued  = 0;
  int            beats_offered = 0;
  int            beats_in      = 0;
  int            quiet_cycles  = 0;
  int            mismatches    = 0;
  int            src_idle_pct  = 0;
  int            sink_stall_pct = 0;
  int            mid_clear_pct = 0;
  int            src_gap  = 0;
  int            sink_gap = 0;

  // Shadow of the decoder: framing state, flags and scale registers
  logic [3:0]                   frame_pos   = '0;
  logic [7:0]                   frame_buf [0:9];
  logic [7:0]                   frame_sum   = '0;
  logic                         accel_flag  = 1'b0;
  logic                         gyro_flag   = 1'b0;
  logic [isfd_pkg::SCALE_W-1:0] acc_gain    = isfd_pkg::SCALE_ONE;
  logic [isfd_pkg::SCALE_W-1:0] rate_gain   = isfd_pkg::SCALE_ONE;

  // Exact signed 16x32 product of one little-endian axis, kept to 48 bits.
  function automatic logic [47:0] scale_axis(logic [7:0] lo, logic [7:0] hi,
                                             logic [isfd_pkg::SCALE_W-1:0] scale);
    logic signed [47:0] prod;
    prod = $signed({hi, lo}) * $signed(scale);
    return prod;
  endfunction

  // Advance the shadow decoder by one accepted beat; queue a sample for a good frame.
  task automatic decode_serial_beat(logic cmd, logic [7:0] b);
    frame_sample_t                s;
    logic [isfd_pkg::SCALE_W-1:0] scale;
    if (cmd == isfd_pkg::CMD_CLEAR) begin
      // clear leaves the framing alone
      accel_flag = 1'b0;
      gyro_flag  = 1'b0;
    end else if (frame_pos == 0 || frame_pos > isfd_pkg::SUM_LEN) begin
      // hunting: drop anything but the header
      frame_pos = '0;
      if (b == isfd_pkg::HDR_BYTE) begin
        frame_buf[0] = b;
        frame_sum    = b;
        frame_pos    = 4'd1;
      end
    end else if (frame_pos < isfd_pkg::SUM_LEN) begin
      frame_buf[frame_pos] = b;
      frame_sum = frame_sum + b;
      frame_pos = frame_pos + 4'd1;
    end else begin
      // checksum byte; bad sums and unknown types emit nothing
      frame_pos = '0;
      if (b == frame_sum && (frame_buf[1] == isfd_pkg::TYPE_ACCEL ||
                             frame_buf[1] == isfd_pkg::TYPE_GYRO)) begin
        if (frame_buf[1] == isfd_pkg::TYPE_ACCEL) begin
          s.kind     = isfd_pkg::KIND_ACCEL;
          accel_flag = 1'b1;
          scale      = acc_gain;
        end else begin
          s.kind    = isfd_pkg::KIND_GYRO;
          gyro_flag = 1'b1;
          scale     = rate_gain;
        end
        s.ax = scale_axis(frame_buf[2], frame_buf[3], scale);
        s.ay = scale_axis(frame_buf[4], frame_buf[5], scale);
        s.az = scale_axis(frame_buf[6], frame_buf[7], scale);
        s.accel_seen = accel_flag;
        s.gyro_seen  = gyro_flag;
        frames_due.push_back(s);
      end
    end
  endtask

  // Compare one output beat with the oldest owed sample.
  task automatic check_sample();
    frame_sample_t got;
    frame_sample_t want;
    got.kind       = m_tuser;
    got.ax         = m_tdata[47:0];
    got.ay         = m_tdata[95:48];
    got.az         = m_tdata[143:96];
    got.accel_seen = m_tdata[144];
    got.gyro_seen  = m_tdata[145];
    if (frames_due.size() == 0) begin
      if (mismatches < 10)
        $display("unexpected sample: kind=%0d x=%h y=%h z=%h seen=%b%b",
                 got.kind, got.ax, got.ay, got.az, got.accel_seen, got.gyro_seen);
      mismatches++;
    end else begin
      want = frames_due.pop_front();
      if (got !== want) begin
        if (mismatches < 10) begin
          $display("sample mismatch: exp kind=%0d x=%h y=%h z=%h seen=%b%b",
                   want.kind, want.ax, want.ay, want.az, want.accel_seen, want.gyro_seen);
          $display("                 got kind=%0d x=%h y=%h z=%h seen=%b%b",
                   got.kind, got.ax, got.ay, got.az, got.accel_seen, got.gyro_seen);
        end
        mismatches++;
      end
    end
  endtask

  // Source side: present queued beats at the falling edge, with random idle bursts.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && beats_in != beats_offered) begin
      // hold the current beat until it is taken
    end else if (src_gap > 0) begin
      s_tvalid <= 1'b0;
      src_gap  <= src_gap - 1;
    end else if (serial_q.size() != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      src_gap  <= $urandom_range(0, 13);
    end else if (serial_q.size() != 0) begin
      s_tvalid      <= 1'b1;
      s_tdata       <= serial_q[0].data;
      s_tuser       <= serial_q[0].cmd;
      beats_offered <= beats_offered + 1;
      void'(serial_q.pop_front());
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // Sink side: random back-pressure bursts.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      m_tready <= 1'b0;
      sink_gap <= sink_gap - 1;
    end else if ($urandom_range(0, 99) < sink_stall_pct) begin
      m_tready <= 1'b0;
      sink_gap <= $urandom_range(0, 13);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Monitor: sample every channel at the rising edge.
  always @(posedge clk) begin : monitor
    bit busy;
    if (!rst) begin
      busy = 1'b0;
      // check results before predicting, so a same-edge input can never feed them
      if (m_tvalid && m_tready) begin
        check_sample();
        busy = 1'b1;
      end
      if (s_tvalid && s_tready) begin
        decode_serial_beat(s_tuser, s_tdata);
        beats_in <= beats_in + 1;
        busy = 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          isfd_pkg::REG_ACC_GAIN:  acc_gain  = cfg_data;
          isfd_pkg::REG_RATE_GAIN: rate_gain = cfg_data;
          default: ;
        endcase
        busy = 1'b1;
      end
      quiet_cycles <= busy ? 0 : quiet_cycles + 1;
    end
  end

  // Watchdog: give up when no beat moves on any channel for too long.
  initial begin : watchdog
    while (quiet_cycles < IDLE_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  task automatic push_item(logic cmd, logic [7:0] data);
    serial_q.push_back('{cmd: cmd, data: data});
    items_queued++;
  endtask

  // Queue one frame; stop_at below 11 truncates it, csum_ok low corrupts the sum.
  task automatic push_frame(logic [7:0] ftype, logic [15:0] ax, logic [15:0] ay,
                            logic [15:0] az, bit csum_ok, int stop_at);
    logic [7:0] fb [0:9];
    logic [7:0] sum;
    int         i;
    fb[0] = isfd_pkg::HDR_BYTE;
    fb[1] = ftype;
    fb[2] = ax[7:0];
    fb[3] = ax[15:8];
    fb[4] = ay[7:0];
    fb[5] = ay[15:8];
    fb[6] = az[7:0];
    fb[7] = az[15:8];
    fb[8] = 8'($urandom);
    fb[9] = 8'($urandom);
    sum = '0;
    for (i = 0; i < 10; i++) sum = sum + fb[i];
    for (i = 0; i < 10 && i < stop_at; i++) begin
      push_item(isfd_pkg::CMD_DATA, fb[i]);
      // a clear may land anywhere inside a frame
      if ($urandom_range(0, 99) < mid_clear_pct) push_item(isfd_pkg::CMD_CLEAR, 8'($urandom));
    end
    if (stop_at > 10)
      push_item(isfd_pkg::CMD_DATA, csum_ok ? sum : sum + 8'($urandom_range(1, 255)));
  endtask

  function automatic logic [15:0] pick_axis();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_type();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return isfd_pkg::TYPE_ACCEL;
    if (r < 90) return isfd_pkg::TYPE_GYRO;
    return 8'($urandom);
  endfunction

  // Mostly well-formed frames, plus noise, stray clears and truncated frames.
  task automatic push_random_traffic(int n_items);
    int target;
    int r;
    int k;
    target = items_queued + n_items;
    while (items_queued < target) begin
      r = $urandom_range(0, 99);
      if (r < 72) begin
        push_frame(pick_type(), pick_axis(), pick_axis(), pick_axis(),
                   $urandom_range(0, 99) < 88, 11);
      end else if (r < 82) begin
        for (k = $urandom_range(1, 6); k > 0; k--) push_item(isfd_pkg::CMD_DATA, 8'($urandom));
      end else if (r < 90) begin
        push_item(isfd_pkg::CMD_CLEAR, 8'($urandom));
      end else begin
        push_frame(pick_type(), pick_axis(), pick_axis(), pick_axis(), 1'b1,
                   $urandom_range(1, 9));
      end
    end
  endtask

  // Eleven non-header bytes finish any open frame and leave the parser hunting.
  task automatic push_flush();
    logic [7:0] b;
    int         i;
    for (i = 0; i < 11; i++) begin
      do b = 8'($urandom); while (b == isfd_pkg::HDR_BYTE);
      push_item(isfd_pkg::CMD_DATA, b);
    end
  endtask

  // Wait until every beat is taken and every sample is back, then let the pipe settle.
  task automatic wait_drained();
    while (serial_q.size() != 0 || beats_in != beats_offered || frames_due.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_scale(logic [isfd_pkg::CFG_AW-1:0] addr,
                             logic [isfd_pkg::SCALE_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [isfd_pkg::SCALE_W-1:0] accel_set [0:5];
    logic [isfd_pkg::SCALE_W-1:0] gyro_set  [0:5];
    int                           phase;
    accel_set = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0, 32'h0,
                  isfd_pkg::SCALE_ONE};
    gyro_set  = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0000_0001};
    accel_set[3] = $urandom;
    gyro_set[3]  = $urandom;
    accel_set[4] = $urandom;
    gyro_set[4]  = $urandom;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: stray byte, accel frame at axis extremes, clear, gyro frame with a
    // bad checksum, then an unknown type with a good checksum. Reset scales apply.
    src_idle_pct   = 10;
    sink_stall_pct = 10;
    push_item(isfd_pkg::CMD_DATA, 8'h00);
    push_frame(isfd_pkg::TYPE_ACCEL, 16'h8000, 16'h7FFF, 16'h0000, 1'b1, 11);
    push_item(isfd_pkg::CMD_CLEAR, 8'hFF);
    push_frame(isfd_pkg::TYPE_GYRO, 16'hFFFF, 16'h0001, 16'h8000, 1'b0, 11);
    push_frame(8'h53, 16'h1234, 16'hEDCB, 16'h00FF, 1'b1, 11);
    push_flush();
    wait_drained();

    // Random phases, each under new scale settings; the last one runs without idling.
    mid_clear_pct = 3;
    for (phase = 0; phase < 6; phase++) begin
      write_scale(isfd_pkg::REG_ACC_GAIN, accel_set[phase]);
      write_scale(isfd_pkg::REG_RATE_GAIN, gyro_set[phase]);
      if (phase == 5) begin
        src_idle_pct   = 0;
        sink_stall_pct = 0;
      end else begin
        src_idle_pct   = $urandom_range(0, 20);
        sink_stall_pct = $urandom_range(0, 20);
      end
      push_random_traffic(190);
      push_flush();
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (frames_due.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
